FILE: rtl/paq_pkg.sv
// Shared types, sizes and codes for the priority admission queue.
package paq_pkg;

  // Store geometry
  localparam int QueueDepth = 16;
  localparam int IDX_W      = $clog2(QueueDepth);
  localparam int OCC_W      = $clog2(QueueDepth + 1);
  localparam int ID_W       = 8;
  localparam int PRIO_W     = 4;
  localparam int RUN_W      = 8;
  localparam int CFG_W      = 8;
  localparam int ENTRY_W    = ID_W + PRIO_W;

  localparam logic [PRIO_W-1:0] PRIO_MAX   = PRIO_W'(15);
  localparam logic [OCC_W-1:0]  OCC_FULL   = OCC_W'(QueueDepth);
  localparam logic [RUN_W-1:0]  RUN_SAT    = {RUN_W{1'b1}};
  localparam logic [CFG_W-1:0]  MAX_RUN_RST = CFG_W'(1);

  // Opcodes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_LEAVE  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_POP_ERR   = 2'd2;
  localparam logic [1:0] ST_UNDERFLOW = 2'd3;

  // One store entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Results of the shared index/compare unit
  typedef struct packed {
    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] idx_dec;
    logic [IDX_W-1:0] idx_dec2;
    logic             greater;
    logic             at_one;
    logic             at_end;
  } walk_t;

endpackage

FILE: rtl/paq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module paq_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/paq_walk_unit.sv
// Shared index stepper and priority comparator used by every walk of the store.
module paq_walk_unit (
  input  logic [paq_pkg::IDX_W-1:0]  idx,
  input  logic [paq_pkg::OCC_W-1:0]  occ,
  input  logic [paq_pkg::PRIO_W-1:0] entry_prio,
  input  logic [paq_pkg::PRIO_W-1:0] req_prio,
  output paq_pkg::walk_t             walk
);
  import paq_pkg::*;

  logic [OCC_W-1:0] idx_wide_inc;

  assign idx_wide_inc = {1'b0, idx} + OCC_W'(1);

  // neighbor indexes for the walk, and the stop tests
  always_comb begin
    walk.idx_inc  = idx + IDX_W'(1);
    walk.idx_dec  = idx - IDX_W'(1);
    walk.idx_dec2 = idx - IDX_W'(2);
    walk.greater  = entry_prio > req_prio;
    walk.at_one   = idx == IDX_W'(1);
    walk.at_end   = idx_wide_inc == occ;
  end

endmodule

FILE: rtl/priority_admission_queue.sv
// Top level of the priority admission queue: sequencer, counters and stream ports.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  s_*     | in        | s_tvalid / s_tready  | opcode, waiter_id, priority_req
//  m_*     | out       | m_tvalid / m_tready  | is_turn, status, head_id, counts
//  cfg_*   | in        | cfg_valid / cfg_ready| max_running
//
// Query, leave, every error case and a pop of the last entry go straight to the finish state.
// Append reads and compares from the tail, shifting each higher-priority entry up, and writes
// the new entry where the walk stops, using the insert state at the head or for an empty queue.
// Pop shifts each later entry down; the store does one write and one registered read per cycle.
// Synchronous reset empties the queue, clears the running count and sets max_running to 1.
// A full output register (m_tready low) holds one more accepted item in its finish state.
module priority_admission_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] opcode, [9:2] waiter_id, [13:10] priority_req, pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] is_turn, [2:1] status, [10:3] head_id,
                                 // [15:11] waiting_count, [23:16] running_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // [7:0] max_running
);
  import paq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_APP_RD  = 3'd1;
  localparam logic [2:0] S_APP_CMP = 3'd2;
  localparam logic [2:0] S_APP_INS = 3'd3;
  localparam logic [2:0] S_POP_RD  = 3'd4;
  localparam logic [2:0] S_POP_MV  = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]        state;
  logic [IDX_W-1:0]  idx;
  logic [OCC_W-1:0]  occupancy;
  logic [RUN_W-1:0]  running;
  logic [CFG_W-1:0]  max_running;
  logic [ID_W-1:0]   head;
  logic [ID_W-1:0]   req_id;
  logic [PRIO_W-1:0] req_prio;
  logic              res_turn;
  logic [1:0]        res_status;
  logic              res_load;

  logic [1:0]        in_op;
  logic [ID_W-1:0]   in_id;
  logic [PRIO_W-1:0] in_prio;
  logic [PRIO_W-1:0] in_prio_clamped;
  logic              in_xfer;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_rdata;
  entry_t            new_entry;
  walk_t             walk;

  // input unpacking and priority clamp
  assign in_op           = s_tdata[1:0];
  assign in_id           = s_tdata[9:2];
  assign in_prio         = s_tdata[13:10];
  assign in_prio_clamped = (in_prio > PRIO_MAX) ? PRIO_MAX : in_prio;
  assign s_tready        = state == S_IDLE;
  assign in_xfer         = s_tvalid && s_tready;
  assign cfg_ready       = 1'b1;
  assign new_entry       = '{id: req_id, prio: req_prio};
  assign res_load        = (state == S_DONE) && (!m_tvalid || m_tready);

  // store
  paq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QueueDepth)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // shared index and compare unit
  paq_walk_unit u_walk (
    .idx       (idx),
    .occ       (occupancy),
    .entry_prio(ram_rdata.prio),
    .req_prio  (req_prio),
    .walk      (walk)
  );

  // store port steering per walk state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = new_entry;
    ram_raddr = idx;
    case (state)
      S_APP_RD: begin
        ram_raddr = walk.idx_dec;
      end
      S_APP_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = walk.greater ? ram_rdata : new_entry;
        ram_raddr = walk.idx_dec2;
      end
      S_APP_INS: begin
        ram_we = 1'b1;
      end
      S_POP_RD: begin
        ram_raddr = IDX_W'(1);
      end
      S_POP_MV: begin
        ram_we    = 1'b1;
        ram_waddr = walk.idx_dec;
        ram_wdata = ram_rdata;
        ram_raddr = walk.idx_inc;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_running <= MAX_RUN_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_running <= cfg_data;
    end
  end

  // sequencer and queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      running   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            req_id   <= in_id;
            req_prio <= in_prio_clamped;
            case (in_op)
              OP_APPEND: begin
                idx      <= occupancy[IDX_W-1:0];
                res_turn <= 1'b0;
                if (occupancy == OCC_FULL) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else if (occupancy == '0) begin
                  res_status <= ST_OK;
                  state      <= S_APP_INS;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_APP_RD;
                end
              end
              OP_QUERY: begin
                res_turn   <= (occupancy != '0) && (running < max_running) && (head == in_id);
                res_status <= ST_OK;
                state      <= S_DONE;
              end
              OP_POP: begin
                res_turn <= 1'b0;
                if (occupancy == '0 || head != in_id) begin
                  res_status <= ST_POP_ERR;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  if (running != RUN_SAT) begin
                    running <= running + RUN_W'(1);
                  end
                  if (occupancy == OCC_W'(1)) begin
                    occupancy <= '0;
                    state     <= S_DONE;
                  end else begin
                    idx   <= IDX_W'(1);
                    state <= S_POP_RD;
                  end
                end
              end
              OP_LEAVE: begin
                res_turn <= 1'b0;
                state    <= S_DONE;
                if (running == '0) begin
                  res_status <= ST_UNDERFLOW;
                end else begin
                  res_status <= ST_OK;
                  running    <= running - RUN_W'(1);
                end
              end
              default: begin
                res_turn   <= 1'b0;
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_APP_RD: begin
          state <= S_APP_CMP;
        end
        S_APP_CMP: begin
          if (walk.greater) begin
            idx <= walk.idx_dec;
            if (walk.at_one) begin
              state <= S_APP_INS;
            end
          end else begin
            occupancy <= occupancy + OCC_W'(1);
            state     <= S_DONE;
          end
        end
        S_APP_INS: begin
          // only reached with the insert point at the head
          head      <= req_id;
          occupancy <= occupancy + OCC_W'(1);
          state     <= S_DONE;
        end
        S_POP_RD: begin
          state <= S_POP_MV;
        end
        S_POP_MV: begin
          if (walk.at_one) begin
            head <= ram_rdata.id;
          end
          if (walk.at_end) begin
            occupancy <= occupancy - OCC_W'(1);
            state     <= S_DONE;
          end else begin
            idx <= walk.idx_inc;
          end
        end
        S_DONE: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata[0]     <= res_turn;
      m_tdata[2:1]   <= res_status;
      m_tdata[10:3]  <= (occupancy != '0) ? head : '0;
      m_tdata[15:11] <= occupancy;
      m_tdata[23:16] <= running;
    end
  end

  // occupancy never passes the store size
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_FULL)
    else $error("occupancy above store depth");

  // occupancy moves by at most one per item
  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    (occupancy != $past(occupancy)) |->
      (occupancy == $past(occupancy) + OCC_W'(1) ||
       occupancy + OCC_W'(1) == $past(occupancy)))
    else $error("occupancy jumped");

  // a new result only appears out of the finish state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("result raised outside finish state");

endmodule

FILE: sim/priority_admission_queue_tb.sv
// Self-checking testbench for the priority admission queue: stream stimulus and scoreboard.
module priority_admission_queue_tb;
  import paq_pkg::*;

  // One result as it travels on m_tdata, lowest field in the lowest bits
  typedef struct packed {
    logic [RUN_W-1:0] running;
    logic [OCC_W-1:0] waiting;
    logic [ID_W-1:0]  head;
    logic [1:0]       status;
    logic             turn;
  } outcome_t;

  // Tracks the sorted waiter store and running count, and checks every result
  class admission_checker;
    logic [ID_W-1:0]   slot_id[QueueDepth];
    logic [PRIO_W-1:0] slot_prio[QueueDepth];
    int                occ;
    logic [RUN_W-1:0]  run;
    logic [CFG_W-1:0]  limit;
    outcome_t          expected_outcomes[$];
    int                errors;

    function new();
      occ    = 0;
      run    = '0;
      limit  = MAX_RUN_RST;
      errors = 0;
    endfunction

    function void set_limit(logic [CFG_W-1:0] v);
      limit = v;
    endfunction

    function logic [ID_W-1:0] head();
      return (occ > 0) ? slot_id[0] : '0;
    endfunction

    function int waiting();
      return occ;
    endfunction

    function logic [RUN_W-1:0] running_now();
      return run;
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    // Apply one accepted request to the tracked state and queue its outcome
    function void note_item(logic [1:0] op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
      outcome_t o;
      int       pos;
      o        = '0;
      o.status = ST_OK;
      case (op)
        OP_APPEND: begin
          if (occ >= QueueDepth) begin
            o.status = ST_FULL;
          end else begin
            // stable insert: behind every entry of lower or equal priority
            pos = 0;
            while (pos < occ && slot_prio[pos] <= prio) pos++;
            for (int k = occ; k > pos; k--) begin
              slot_id[k]   = slot_id[k-1];
              slot_prio[k] = slot_prio[k-1];
            end
            slot_id[pos]   = id;
            slot_prio[pos] = prio;
            occ++;
          end
        end
        OP_QUERY: begin
          o.turn = (occ > 0) && (run < limit) && (slot_id[0] == id);
        end
        OP_POP: begin
          if (occ == 0 || slot_id[0] != id) begin
            o.status = ST_POP_ERR;
          end else begin
            for (int k = 1; k < occ; k++) begin
              slot_id[k-1]   = slot_id[k];
              slot_prio[k-1] = slot_prio[k];
            end
            occ--;
            if (run != RUN_SAT) run++;
          end
        end
        default: begin
          if (run == 0) o.status = ST_UNDERFLOW;
          else run--;
        end
      endcase
      o.head    = head();
      o.waiting = OCC_W'(occ);
      o.running = run;
      expected_outcomes.push_back(o);
    endfunction

    // Compare one result transfer against the oldest outcome
    function void check_result(logic [23:0] d);
      outcome_t want, got;
      got = d;
      if (expected_outcomes.size() == 0) begin
        $error("result %h with no request outstanding", d);
        errors++;
        return;
      end
      want = expected_outcomes.pop_front();
      if (got.turn != want.turn) begin
        $error("is_turn: expected %0d, got %0d", want.turn, got.turn);
        errors++;
      end
      if (got.status != want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.head != want.head) begin
        $error("head_id: expected %0d, got %0d", want.head, got.head);
        errors++;
      end
      if (got.waiting != want.waiting) begin
        $error("waiting_count: expected %0d, got %0d", want.waiting, got.waiting);
        errors++;
      end
      if (got.running != want.running) begin
        $error("running_count: expected %0d, got %0d", want.running, got.running);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  admission_checker sb = new();
  int               tx_count = 0;
  bit               tx_quiet = 1'b0;

  priority_admission_queue DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 10 unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one request; returns at the edge where it was taken
  task automatic send_op(logic [1:0] op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
    int gap;
    // switch between idle-free stretches and gappy ones every 32 requests
    if (tx_count % 32 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    tx_count++;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, prio, id, op};
    do @(posedge clk); while (!s_tready);
    sb.note_item(op, id, prio);
  endtask

  // Hold off requests until every outstanding result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Register write, only with the queue idle
  task automatic write_max_running(logic [CFG_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_limit(v);
  endtask

  // Random mix of all four opcodes; queries and pops are mostly aimed at the head
  task automatic run_mixed(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35)
        send_op(OP_APPEND, ID_W'($urandom), PRIO_W'($urandom));
      else if (r < 55)
        send_op(OP_QUERY, (sb.waiting() > 0 && $urandom_range(0, 3) != 0) ?
                sb.head() : ID_W'($urandom), PRIO_W'($urandom));
      else if (r < 80)
        send_op(OP_POP, (sb.waiting() > 0 && $urandom_range(0, 6) != 0) ?
                sb.head() : ID_W'($urandom), PRIO_W'($urandom));
      else
        send_op(OP_LEAVE, ID_W'($urandom), PRIO_W'($urandom));
    end
  endtask

  // Result side: ready high for a while, then a random stall
  initial begin
    int on_len, gap;
    @(posedge clk iff !rst);
    forever begin
      m_tready <= 1'b1;
      on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 8);
      repeat (on_len) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Stimulus
  initial begin
    int sat_pops;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    m_tready  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty queue: query answers no, pop fails, leave underflows
    send_op(OP_QUERY, 8'h5A, 4'd0);
    send_op(OP_POP, 8'h00, 4'd0);
    send_op(OP_LEAVE, 8'h00, 4'd0);
    // Fill the store with repeated priorities, both id and priority extremes
    for (int k = 0; k < QueueDepth; k++) begin
      send_op(OP_APPEND, (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : ID_W'(k * 16 + 3),
              (k % 4 == 0) ? 4'd0 : (k % 4 == 1) ? PRIO_MAX : (k % 4 == 2) ? 4'd7 : 4'd3);
    end
    send_op(OP_APPEND, 8'h77, 4'd5);        // store full
    send_op(OP_QUERY, 8'h01, 4'd0);         // not the head
    send_op(OP_QUERY, sb.head(), 4'd0);     // head with a free slot
    send_op(OP_POP, 8'h01, 4'd0);           // wrong id
    send_op(OP_POP, sb.head(), 4'd0);
    send_op(OP_QUERY, sb.head(), 4'd0);     // head, but no free slot
    send_op(OP_POP, sb.head(), 4'd0);       // admitted past the slot limit
    send_op(OP_LEAVE, 8'h00, 4'd0);

    // Random mix at a small limit from 2 to 6, then at zero
    write_max_running(CFG_W'($urandom_range(2, 6)));
    run_mixed(60);
    write_max_running(8'd0);
    run_mixed(20);

    // Drive the running count into saturation with well-formed appends and pops at the head
    write_max_running(8'd255);
    sat_pops = 0;
    while (sat_pops < 4) begin
      if (sb.waiting() == 0 || (sb.waiting() < QueueDepth && $urandom_range(0, 1) == 0)) begin
        send_op(OP_APPEND, ID_W'($urandom), PRIO_W'($urandom));
      end else if ($urandom_range(0, 9) == 0) begin
        send_op(OP_QUERY, sb.head(), PRIO_W'($urandom));
      end else begin
        if (sb.running_now() == RUN_SAT) sat_pops++;
        send_op(OP_POP, sb.head(), PRIO_W'($urandom));
      end
    end
    // Slot limit at its top: no turn at 255 running, a turn once one leaves
    send_op(OP_APPEND, ID_W'($urandom), PRIO_W'($urandom));
    send_op(OP_QUERY, sb.head(), 4'd0);
    send_op(OP_LEAVE, 8'h00, 4'd0);
    send_op(OP_QUERY, sb.head(), 4'd0);

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
